### hw/rtl/nus_pkg.sv
// Shared constants and the output group type of the NAL unit splitter.
package nus_pkg;

    // Longest unit given out before it is cut
    localparam int unsigned MAX_NAL_BYTES = 65536;
    localparam int unsigned ROOM_W        = $clog2(MAX_NAL_BYTES);

    // Bytes that one input beat can release at most
    localparam int unsigned GROUP_BYTES = 4;
    localparam int unsigned SLOT_W      = $clog2(GROUP_BYTES);
    localparam int unsigned GCNT_W      = $clog2(GROUP_BYTES + 1);

    // Group queue between the front and the back
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] START_BYTE     = 8'h01;
    localparam logic [4:0] TYPE_DELIMITER = 5'd9;

    // Bytes released by one input beat; last and oversize belong to the final slot
    typedef struct packed {
        logic [GCNT_W-1:0]                cnt;
        logic [GROUP_BYTES-1:0][7:0]      bytes;
        logic [4:0]                       utype;
        logic                             first;
        logic                             last;
        logic                             ov;
    } t_group;

endpackage

### hw/rtl/nus_front.sv
// Front end: start code search, unit state and grouping of released bytes.
module nus_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_eos,
    output logic             o_push,
    output nus_pkg::t_group  o_group
);

    logic                       r_drop;
    logic                       r_inside;
    logic                       r_disc;
    logic                       r_hp;
    logic [4:0]                 r_type;
    logic [nus_pkg::ROOM_W-1:0] r_room;
    logic [2:0]                 r_count;
    logic [7:0]                 r_held0;

    logic [4:0][7:0] a;
    logic [2:0]      z;
    logic [2:0]      zmin;
    logic [2:0]      zz;
    logic [2:0]      m;
    logic [2:0]      keep;
    logic [2:0]      k;
    logic            lastf;
    logic            hdr;
    logic [4:0]      type_new;
    logic            disc_new;
    logic            sc;
    logic            active;
    logic            room_lt;
    logic            room_eq;
    logic            cut;
    logic [2:0]      emit;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            if (3'(i) < r_count) begin
                a[i] = (i == 0) ? r_held0 : 8'h00;
            end else if (3'(i) == r_count) begin
                a[i] = i_byte;
            end else begin
                a[i] = 8'h00;
            end
        end
    end

    // held bytes are one candidate byte followed only by zeros
    always_comb begin
        if (r_count == 3'd0) begin
            z = 3'd0;
        end else if (r_held0 == 8'h00) begin
            z = r_count;
        end else begin
            z = r_count - 3'd1;
        end
    end

    assign zmin     = (z > 3'd3) ? 3'd3 : z;
    assign m        = r_count + 3'd1;
    assign hdr      = r_inside && !r_disc && r_hp && (r_count == 3'd0);
    assign type_new = hdr ? i_byte[4:0] : r_type;
    assign disc_new = r_disc || (hdr && r_drop && (i_byte[4:0] == nus_pkg::TYPE_DELIMITER));
    assign sc       = (i_byte == nus_pkg::START_BYTE) && (z >= 3'd2);

    always_comb begin
        zz   = (i_byte != 8'h00) ? 3'd0 : z + 3'd1;
        keep = ((zz > 3'd3) ? 3'd3 : zz) + 3'd1;
        if (keep > m) begin
            keep = m;
        end
        if (sc) begin
            k     = r_count - zmin;
            lastf = 1'b1;
        end else if (i_eos) begin
            k     = (r_count == 3'd4) ? 3'd4 : m;
            lastf = 1'b1;
        end else begin
            k     = m - keep;
            lastf = 1'b0;
        end
    end

    // cut where the byte count reaches the limit, unless that byte ends the unit anyway
    assign active  = r_inside && !disc_new;
    assign room_lt = r_room < nus_pkg::ROOM_W'(k);
    assign room_eq = r_room == nus_pkg::ROOM_W'(k - 3'd1);
    assign cut     = active && room_lt && !(lastf && room_eq);

    always_comb begin
        if (!active) begin
            emit = 3'd0;
        end else if (cut) begin
            emit = 3'(r_room[1:0]) + 3'd1;
        end else begin
            emit = k;
        end
    end

    always_comb begin
        o_group.cnt   = emit;
        for (int i = 0; i < nus_pkg::GROUP_BYTES; i++) begin
            o_group.bytes[i] = a[i];
        end
        o_group.utype = type_new;
        o_group.first = r_hp;
        o_group.last  = cut || lastf;
        o_group.ov    = cut;
    end

    assign o_push = i_accept && (emit != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop   <= 1'b1;
            r_inside <= 1'b0;
            r_disc   <= 1'b0;
            r_hp     <= 1'b0;
            r_type   <= 5'd0;
            r_room   <= nus_pkg::ROOM_W'(nus_pkg::MAX_NAL_BYTES - 1);
            r_count  <= 3'd0;
            r_held0  <= 8'h00;
        end else begin
            if (i_cfg_we) begin
                r_drop <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_type <= type_new;
                if (sc || i_eos) begin
                    // open a new unit, or search again after the stream ends
                    r_inside <= sc && !i_eos;
                    r_hp     <= sc && !i_eos;
                    r_disc   <= 1'b0;
                    r_room   <= nus_pkg::ROOM_W'(nus_pkg::MAX_NAL_BYTES - 1);
                    r_count  <= 3'd0;
                    r_held0  <= 8'h00;
                end else begin
                    r_disc  <= disc_new || cut;
                    r_hp    <= r_hp && (emit == 3'd0);
                    r_room  <= r_room - nus_pkg::ROOM_W'(emit);
                    r_count <= keep;
                    r_held0 <= a[k];
                end
            end
        end
    end

endmodule

### hw/rtl/nus_queue.sv
// Group queue that decouples the front end from the output side.
module nus_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nus_pkg::t_group  i_group,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output nus_pkg::t_group  o_head
);

    nus_pkg::t_group              r_mem [nus_pkg::QDEPTH];
    logic [nus_pkg::QPTR_W-1:0]   r_wptr;
    logic [nus_pkg::QPTR_W-1:0]   r_rptr;
    logic [nus_pkg::QPTR_W:0]     r_cnt;

    assign o_full  = r_cnt == (nus_pkg::QPTR_W + 1)'(nus_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/nus_back.sv
// Back end: walks the head group and drives one output beat per byte.
module nus_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  nus_pkg::t_group  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data,
    output logic [6:0]       o_user,
    output logic             o_last
);

    logic [nus_pkg::SLOT_W-1:0] r_idx;
    logic                       last_slot;

    assign last_slot = (nus_pkg::GCNT_W'(r_idx) + 1'b1) == i_head.cnt;
    assign o_valid   = !i_empty;
    assign o_data    = i_head.bytes[r_idx];
    assign o_user    = {i_head.ov && last_slot, i_head.first && (r_idx == '0), i_head.utype};
    assign o_last    = i_head.last && last_slot;
    assign o_pop     = o_valid && i_ready && last_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            // advance within the group, rewind when it is retired
            r_idx <= last_slot ? '0 : r_idx + 1'b1;
        end
    end

endmodule

### hw/rtl/h264_nal_unit_splitter_top.sv
// Top level of the H.264 Annex B NAL unit splitter.
// Takes an Annex B byte stream one beat per clock and gives out the bytes of each NAL
// unit with its start code stripped, one beat per clock while the sink is ready. The
// input side never waits on the output as long as the 8-entry group queue has room: each
// input beat is searched for start codes combinationally and the up to four bytes it
// releases are queued as one group; the output side then sends a group one byte per
// cycle, so a beat's bytes appear at the earliest in the cycle after it is accepted. The
// last byte of a unit and up to three trailing zeros are held back until the next start
// code or end of stream decides their fate. The delimiter-drop register resets to 1 and
// is written with i_cfg_we high; change it only while no stream is in flight.
module h264_nal_unit_splitter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,     // drop_delimiters
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,       // [7:0] stream_byte
    input  logic       i_s_tlast,       // end_of_stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,       // [7:0] unit_byte
    output logic [6:0] o_m_tuser,       // [4:0] unit_type, [5] first_of_unit, [6] oversize
    output logic       o_m_tlast        // last_of_unit
);

    logic            s_accept;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    nus_pkg::t_group grp_in;
    nus_pkg::t_group grp_head;

    assign o_s_tready = !full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    nus_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (s_accept),
        .i_byte      (i_s_tdata),
        .i_eos       (i_s_tlast),
        .o_push      (push),
        .o_group     (grp_in)
    );

    nus_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (grp_head)
    );

    nus_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (grp_head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser),
        .o_last  (o_m_tlast)
    );

endmodule

### test/tb_h264_nal_unit_splitter_top.sv
// Self-checking testbench for the H.264 Annex B NAL unit splitter top level.
`timescale 1ns / 1ps

module tb_h264_nal_unit_splitter_top;

    localparam int unsigned RUN_LIMIT_NS = 400_000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 32;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] utype;
        logic       first;
        logic       last;
        logic       ov;
    } t_nal_beat;

    class nal_scoreboard;
        t_nal_beat   unit_bytes_due[$];
        int unsigned errors;
        logic [7:0]  held[4];
        int          held_cnt;
        bit          in_unit;
        bit          discarding;
        bit          hdr_pending;
        logic [4:0]  cur_type;
        int unsigned ulen;
        bit          drop_aud;

        function new();
            errors   = 0;
            drop_aud = 1'b1;
            to_search();
        endfunction

        function void clear_held();
            for (int i = 0; i < 4; i++) held[i] = 8'h00;
            held_cnt = 0;
        endfunction

        function void to_search();
            clear_held();
            in_unit     = 1'b0;
            discarding  = 1'b0;
            hdr_pending = 1'b0;
            cur_type    = 5'd0;
            ulen        = 0;
        endfunction

        function void open_unit();
            clear_held();
            in_unit     = 1'b1;
            discarding  = 1'b0;
            hdr_pending = 1'b1;
            ulen        = 0;
        endfunction

        function int tail_zeros(logic [7:0] v[5], int n);
            int c;
            c = 0;
            while (c < n && v[n-1-c] == 8'h00) c++;
            return c;
        endfunction

        // Queue one unit byte; cut the unit when it reaches the size limit.
        function void emit(logic [7:0] v, bit last);
            t_nal_beat e;
            bit        ov;
            ov = 1'b0;
            if (!in_unit || discarding) return;
            ulen++;
            if (!last && ulen >= nus_pkg::MAX_NAL_BYTES) begin
                last       = 1'b1;
                ov         = 1'b1;
                discarding = 1'b1;
            end
            e.data  = v;
            e.utype = cur_type;
            e.first = hdr_pending;
            e.last  = last;
            e.ov    = ov;
            unit_bytes_due.push_back(e);
            hdr_pending = 1'b0;
        endfunction

        function void note_beat(logic [7:0] b, logic eos);
            logic [7:0] a[5];
            int         z;
            int         r;
            int         m;
            int         lim;
            int         keep;
            int         e;
            for (int i = 0; i < 5; i++) a[i] = (i < 4) ? held[i] : 8'h00;
            if (in_unit && !discarding && hdr_pending && held_cnt == 0) begin
                cur_type = b[4:0];
                if (drop_aud && cur_type == nus_pkg::TYPE_DELIMITER) discarding = 1'b1;
            end
            z = tail_zeros(a, held_cnt);
            if (b == nus_pkg::START_BYTE && z >= 2) begin
                r = held_cnt - ((z > 3) ? 3 : z);
                for (int i = 0; i < r; i++) emit(a[i], i + 1 == r);
                if (eos) to_search();
                else open_unit();
                return;
            end
            a[held_cnt] = b;
            m = held_cnt + 1;
            if (eos) begin
                lim = (m > 4) ? 4 : m;
                for (int i = 0; i < lim; i++) emit(a[i], i + 1 == lim);
                to_search();
                return;
            end
            z    = tail_zeros(a, m);
            keep = ((z > 3) ? 3 : z) + 1;
            if (keep > m) keep = m;
            e = m - keep;
            for (int i = 0; i < e; i++) emit(a[i], 1'b0);
            for (int i = 0; i < keep; i++) held[i] = a[e + i];
            held_cnt = keep;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_beat(logic [7:0] data, logic [6:0] tuser, logic tlast);
            t_nal_beat exp_b;
            if (unit_bytes_due.size() == 0) begin
                report($sformatf("unexpected byte %02h", data));
                return;
            end
            exp_b = unit_bytes_due.pop_front();
            if (data !== exp_b.data)
                report($sformatf("unit_byte %02h, want %02h", data, exp_b.data));
            if (tuser[4:0] !== exp_b.utype)
                report($sformatf("unit_type %0d, want %0d", tuser[4:0], exp_b.utype));
            if (tuser[5] !== exp_b.first)
                report($sformatf("first_of_unit %b, want %b", tuser[5], exp_b.first));
            if (tlast !== exp_b.last)
                report($sformatf("last_of_unit %b, want %b", tlast, exp_b.last));
            if (tuser[6] !== exp_b.ov)
                report($sformatf("oversize %b, want %b", tuser[6], exp_b.ov));
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       i_s_tlast   = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;
    logic [6:0] o_m_tuser;
    logic       o_m_tlast;

    nal_scoreboard sb;
    int unsigned   send_idle = 14;
    int unsigned   recv_idle = 47;
    bit            hold_req  = 1'b0;

    h264_nal_unit_splitter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one beat, idling at random first; returns at the falling edge after the accept.
    task automatic send_beat(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_beat(b, eos);
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [8:0] seq[$]);
        foreach (seq[i]) send_beat(seq[i][7:0], seq[i][8]);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return nus_pkg::START_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] payload_byte();
        int k;
        k = $urandom_range(99);
        if (k < 35) return 8'h00;
        if (k < 40) return nus_pkg::START_BYTE;
        return 8'($urandom);
    endfunction

    // Mostly well-formed units with random content, some noise and early ends.
    task automatic send_random(input int n_items);
        int         sent;
        int         k;
        int         n;
        int         len;
        bit         eos;
        logic [7:0] hdr;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(99);
            if (k < 15) begin
                n = $urandom_range(1, 6);
                repeat (n) send_beat(noise_byte(), 1'b0);
                sent += n;
            end else begin
                n = $urandom_range(2, 5);
                repeat (n) send_beat(8'h00, 1'b0);
                sent += n;
                eos = ($urandom_range(99) < 4);
                send_beat(nus_pkg::START_BYTE, eos);
                sent++;
                if (!eos && $urandom_range(99) >= 8) begin
                    case ($urandom_range(3))
                        0: hdr = {3'($urandom_range(7)), nus_pkg::TYPE_DELIMITER};
                        1: hdr = 8'h00;
                        default: hdr = 8'($urandom);
                    endcase
                    len = $urandom_range(0, 10);
                    eos = (k >= 90);
                    send_beat(hdr, eos && len == 0);
                    for (int i = 0; i < len; i++) send_beat(payload_byte(), eos && i == len - 1);
                    sent += len + 1;
                end
            end
        end
        // close any open unit so the block ends up searching
        send_beat(8'($urandom), 1'b1);
        i_s_tvalid <= 1'b0;
    endtask

    // Wait out the queue, then let the block settle before touching the register.
    task automatic write_drop(input logic v);
        while (sb.unit_bytes_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        sb.drop_aud = v;
        i_cfg_we    <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_beat(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // hold off long enough that the group queue fills and input stalls
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("h264_nal_unit_splitter_top verification failed");
        $finish;
    end

    initial begin
        logic [8:0] intro[$];
        logic [8:0] keep_aud[$];
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // garbage before the first code, a four-zero code, an empty unit, a delimiter,
        // a zero header and a crowded end of stream
        intro = '{9'h0FF, 9'h000, 9'h001,
                  9'h000, 9'h000, 9'h001, 9'h065, 9'h080,
                  9'h000, 9'h000, 9'h000, 9'h000, 9'h001,
                  9'h000, 9'h000, 9'h001,
                  9'h009, 9'h0F0,
                  9'h000, 9'h000, 9'h001, 9'h000, 9'h0AB,
                  9'h000, 9'h000, 9'h000, 9'h1AA};
        send_seq(intro);
        send_random(40);

        write_drop(1'b0);
        send_idle = 47;
        recv_idle = 14;
        // kept delimiter, start code on the final byte, header-only unit at the end
        keep_aud = '{9'h000, 9'h000, 9'h001, 9'h009, 9'h011, 9'h022, 9'h000, 9'h000, 9'h101,
                     9'h000, 9'h000, 9'h001, 9'h1E5};
        send_seq(keep_aud);
        hold_req = 1'b1;
        send_random(40);

        write_drop(1'b1);
        send_idle = 0;
        recv_idle = 0;
        send_random(40);

        while (sb.unit_bytes_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.unit_bytes_due.size() == 0) begin
            $display("h264_nal_unit_splitter_top verification clean");
        end else begin
            $display("h264_nal_unit_splitter_top verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/nus_pkg.sv
hw/rtl/nus_front.sv
hw/rtl/nus_queue.sv
hw/rtl/nus_back.sv
hw/rtl/h264_nal_unit_splitter_top.sv
test/tb_h264_nal_unit_splitter_top.sv
